[rtl/mbpr_pkg.sv]
// ----------------------------------------------------------------------------
// mbpr_pkg
// Shared constants, pipeline types and the ballot-count lookup for the
// masked ballot path rank unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mbpr_pkg;

    localparam int WORD_W  = 32;   // path_word
    localparam int MASK_W  = 16;   // position_mask, one bit per position
    localparam int START_W = 5;    // start_height
    localparam int RANK_W  = 16;   // rank
    localparam int SYM_W   = 2;

    localparam int POSITIONS       = 16;   // scanned positions, 1..16
    localparam int LANES_PER_STAGE = 4;    // positions resolved per scan stage
    localparam int SCAN_STAGES     = (POSITIONS + LANES_PER_STAGE - 1) / LANES_PER_STAGE;

    // left-align the scanned positions so every stage consumes the top bits
    localparam int ALIGN_POS  = MASK_W - POSITIONS;
    localparam int ALIGN_BITS = SYM_W * ALIGN_POS;

    localparam int HEIGHT_W = START_W + 1;        // start up to 31 plus 16 up steps
    localparam int LEFT_W   = $clog2(MASK_W + 1); // remaining active positions
    localparam int LEN_W    = $clog2(MASK_W);     // suffix length, 0..15

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = SYM_W;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UP_SYMBOL   = 1'b0,
        CFG_DOWN_SYMBOL = 1'b1
    } t_cfg_idx;

    // item state carried through the scan stages
    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic [MASK_W-1:0]   mask;
        logic [HEIGHT_W-1:0] height;
        logic [LEFT_W-1:0]   left;
        logic [RANK_W-1:0]   rank;
        logic                ok;
    } t_scan;

    // symbol codes shared by all scan stages
    typedef struct packed {
        logic [SYM_W-1:0] up_sym;
        logic [SYM_W-1:0] down_sym;
    } t_sym_cfg;

    localparam logic [15:0] BINOM_TAB [16][16] = '{
        '{16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd1, 16'd2, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd1, 16'd3, 16'd3, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd1, 16'd4, 16'd6, 16'd4, 16'd1, 16'd0, 16'd0, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd1, 16'd5, 16'd10, 16'd10, 16'd5, 16'd1, 16'd0, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd1, 16'd6, 16'd15, 16'd20, 16'd15, 16'd6, 16'd1, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd1, 16'd7, 16'd21, 16'd35, 16'd35, 16'd21, 16'd7, 16'd1,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd1, 16'd8, 16'd28, 16'd56, 16'd70, 16'd56, 16'd28, 16'd8,
          16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd1, 16'd9, 16'd36, 16'd84, 16'd126, 16'd126, 16'd84, 16'd36,
          16'd9, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd1, 16'd10, 16'd45, 16'd120, 16'd210, 16'd252, 16'd210, 16'd120,
          16'd45, 16'd10, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd1, 16'd11, 16'd55, 16'd165, 16'd330, 16'd462, 16'd462, 16'd330,
          16'd165, 16'd55, 16'd11, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0},
        '{16'd1, 16'd12, 16'd66, 16'd220, 16'd495, 16'd792, 16'd924, 16'd792,
          16'd495, 16'd220, 16'd66, 16'd12, 16'd1, 16'd0, 16'd0, 16'd0},
        '{16'd1, 16'd13, 16'd78, 16'd286, 16'd715, 16'd1287, 16'd1716, 16'd1716,
          16'd1287, 16'd715, 16'd286, 16'd78, 16'd13, 16'd1, 16'd0, 16'd0},
        '{16'd1, 16'd14, 16'd91, 16'd364, 16'd1001, 16'd2002, 16'd3003, 16'd3432,
          16'd3003, 16'd2002, 16'd1001, 16'd364, 16'd91, 16'd14, 16'd1, 16'd0},
        '{16'd1, 16'd15, 16'd105, 16'd455, 16'd1365, 16'd3003, 16'd5005, 16'd6435,
          16'd6435, 16'd5005, 16'd3003, 16'd1365, 16'd455, 16'd105, 16'd15, 16'd1}
    };

    // paths of length n from height h back to zero that never go below zero
    function automatic logic [RANK_W-1:0] ballot_count(
        input logic [LEN_W-1:0]    n,
        input logic [HEIGHT_W-1:0] h
    );
        logic [LEN_W-1:0]  d;
        logic [LEN_W-2:0]  u;
        logic [RANK_W-1:0] res;
        d   = n - h[LEN_W-1:0];
        u   = d[LEN_W-1:1];
        res = '0;
        if ({{(HEIGHT_W-LEN_W){1'b0}}, n} >= h && !d[0]) begin
            if (u == '0) begin
                res = RANK_W'(1);
            end else begin
                res = BINOM_TAB[n][{1'b0, u}] - BINOM_TAB[n][{1'b0, u - 1'b1}];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/mbpr_in_if.sv]
// ----------------------------------------------------------------------------
// mbpr_in_if
// Path channel: valid/ready handshake with the path word, mask and height.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbpr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] path_word;
    logic [15:0] position_mask;
    logic [4:0]  start_height;

    modport source (output valid, output path_word, output position_mask,
                    output start_height, input ready);
    modport sink   (input valid, input path_word, input position_mask,
                    input start_height, output ready);
endinterface

`default_nettype wire

[rtl/mbpr_out_if.sv]
// ----------------------------------------------------------------------------
// mbpr_out_if
// Result channel: valid/ready handshake with rank and rank_valid.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbpr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] rank;
    logic        rank_valid;

    modport source (output valid, output rank, output rank_valid, input ready);
    modport sink   (input valid, input rank, input rank_valid, output ready);
endinterface

`default_nettype wire

[rtl/mbpr_front.sv]
// ----------------------------------------------------------------------------
// mbpr_front
// Entry stage: aligns the scanned positions to the top and counts the
// active positions of the whole mask.
// ----------------------------------------------------------------------------
`default_nettype none

module mbpr_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    mbpr_in_if.sink              i_in,
    output logic                 o_valid,
    output mbpr_pkg::t_scan      o_data,
    input  wire logic            i_ready
);
    import mbpr_pkg::*;

    logic  r_valid;
    t_scan r_data;
    t_scan n_data;
    logic  load;
    logic [LEFT_W-1:0] n_left;

    assign load       = !r_valid || i_ready;
    // no transfer is taken while reset is held
    assign i_in.ready = load && i_rst_n;

    always_comb begin
        n_left = '0;
        for (int b = 0; b < MASK_W; b++) begin
            n_left = n_left + LEFT_W'(i_in.position_mask[b]);
        end
        n_data.word   = i_in.path_word << ALIGN_BITS;
        n_data.mask   = i_in.position_mask << ALIGN_POS;
        n_data.height = {1'b0, i_in.start_height};
        n_data.left   = n_left;
        n_data.rank   = '0;
        n_data.ok     = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_in.valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

[rtl/mbpr_scan_stage.sv]
// ----------------------------------------------------------------------------
// mbpr_scan_stage
// One scan stage: resolves the top four positions of the aligned path,
// updates height, rank and remaining count, then shifts them out.
// ----------------------------------------------------------------------------
`default_nettype none

module mbpr_scan_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mbpr_pkg::t_sym_cfg i_cfg,
    input  wire logic              i_valid,
    input  wire mbpr_pkg::t_scan   i_data,
    output logic                   o_ready,
    output logic                   o_valid,
    output mbpr_pkg::t_scan        o_data,
    input  wire logic              i_ready
);
    import mbpr_pkg::*;

    logic  r_valid;
    t_scan r_data;
    t_scan n_data;
    logic  load;

    assign load    = !r_valid || i_ready;
    assign o_ready = load;

    always_comb begin
        logic [SYM_W-1:0] sym;
        n_data = i_data;
        for (int j = 0; j < LANES_PER_STAGE; j++) begin
            sym = n_data.word[WORD_W-1 -: SYM_W];
            if (n_data.mask[MASK_W-1] && n_data.ok) begin
                if (sym == i_cfg.up_sym) begin
                    if (n_data.height != '0) begin
                        n_data.rank = n_data.rank
                            + ballot_count(LEN_W'(n_data.left - 1'b1),
                                           n_data.height - 1'b1);
                    end
                    n_data.height = n_data.height + 1'b1;
                end else if (sym == i_cfg.down_sym) begin
                    if (n_data.height == '0) begin
                        n_data.ok = 1'b0;
                    end else begin
                        n_data.height = n_data.height - 1'b1;
                    end
                end else begin
                    n_data.ok = 1'b0;   // unknown symbol
                end
                n_data.left = n_data.left - 1'b1;
            end
            n_data.word = n_data.word << SYM_W;
            n_data.mask = n_data.mask << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

[rtl/mbpr_back.sv]
// ----------------------------------------------------------------------------
// mbpr_back
// Output stage: final validity check and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbpr_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire mbpr_pkg::t_scan i_data,
    output logic                 o_ready,
    mbpr_out_if.source           o_out
);
    import mbpr_pkg::*;

    logic              r_valid;
    logic [RANK_W-1:0] r_rank;
    logic              r_rank_valid;
    logic              path_ok;
    logic              load;

    assign load    = !r_valid || o_out.ready;
    assign o_ready = load;

    // must end at height zero with every counted position consumed
    assign path_ok = i_data.ok && (i_data.height == '0) && (i_data.left == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_rank       <= path_ok ? i_data.rank : '0;
            r_rank_valid <= path_ok;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.rank       = r_rank;
    assign o_out.rank_valid = r_rank_valid;

endmodule

`default_nettype wire

[rtl/masked_ballot_path_rank_unit.sv]
// ----------------------------------------------------------------------------
// masked_ballot_path_rank_unit
// Ranks a masked path of 2-bit step symbols among all valid ballot paths.
// ----------------------------------------------------------------------------
// Pipeline: six register stages (entry stage, four scan stages of four
//   positions each, output register).
// Throughput: one path per cycle while the sink accepts results; every stage has its own valid bit and
//   takes a new item whenever it is empty or its successor moves.
// Reset: synchronous, active low; clears all stage valid bits, holds input
//   ready low and sets up_symbol to 0 and down_symbol to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_ballot_path_rank_unit (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [mbpr_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [mbpr_pkg::CFG_W-1:0]             i_cfg_data,
    mbpr_in_if.sink                                     i_in,
    mbpr_out_if.source                                  o_out
);
    import mbpr_pkg::*;

    // symbol code registers; the user must write them only while the pipe is drained, the block does not enforce it
    logic [SYM_W-1:0] r_up_sym;
    logic [SYM_W-1:0] r_down_sym;
    t_sym_cfg         sym_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_sym   <= SYM_W'(0);
            r_down_sym <= SYM_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_UP_SYMBOL:   r_up_sym   <= i_cfg_data;
                CFG_DOWN_SYMBOL: r_down_sym <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign sym_cfg.up_sym   = r_up_sym;
    assign sym_cfg.down_sym = r_down_sym;

    // stage k drives index k; the entry stage is index 0, the last scan
    // stage feeds the output register through index SCAN_STAGES
    logic  stg_valid [SCAN_STAGES+1];
    logic  stg_ready [SCAN_STAGES+1];
    t_scan stg_data  [SCAN_STAGES+1];

    mbpr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (stg_valid[0]),
        .o_data  (stg_data[0]),
        .i_ready (stg_ready[0])
    );

    // scan positions from the most significant one downward
    for (genvar k = 0; k < SCAN_STAGES; k++) begin : g_scan
        mbpr_scan_stage u_scan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (sym_cfg),
            .i_valid (stg_valid[k]),
            .i_data  (stg_data[k]),
            .o_ready (stg_ready[k]),
            .o_valid (stg_valid[k+1]),
            .o_data  (stg_data[k+1]),
            .i_ready (stg_ready[k+1])
        );
    end

    // final check and result register; the sink's ready passes combinationally to the last scan stage
    mbpr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid[SCAN_STAGES]),
        .i_data  (stg_data[SCAN_STAGES]),
        .o_ready (stg_ready[SCAN_STAGES]),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
